// File: rtl/crpf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crpf_pkg: shared types and constants for the center rotation pixel fetch
// Payload structs, register indexes, controller states and reset values.
// ----------------------------------------------------------------------------
package crpf_pkg;

    localparam int ROW_W   = 9;
    localparam int COL_W   = 10;
    localparam int CHAN_W  = 8;
    localparam int PIX_W   = 3 * CHAN_W;
    localparam int FW_W    = 11;
    localparam int FH_W    = 10;
    localparam int TRIG_W  = 16;
    localparam int CFG_W   = 16;
    localparam int REG_IDX_W = 2;

    // Offsets from the center; wide enough for any column and half width.
    localparam int DIFF_W = 12;
    localparam int PROD_W = DIFF_W + TRIG_W;
    localparam int SUM_W  = PROD_W + 1;

    localparam int DEF_MAX_WIDTH      = 1024;
    localparam int DEF_MAX_HEIGHT     = 512;
    localparam int DEF_TRIG_FRAC_BITS = 14;

    localparam logic [FW_W-1:0]   RST_FRAME_WIDTH  = 11'd640;
    localparam logic [FH_W-1:0]   RST_FRAME_HEIGHT = 10'd480;
    localparam logic [TRIG_W-1:0] RST_COS_ANGLE    = 16'h4000;
    localparam logic [TRIG_W-1:0] RST_SIN_ANGLE    = 16'h0000;

    localparam logic ACT_STORE = 1'b0;
    localparam logic ACT_FETCH = 1'b1;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_FRAME_WIDTH  = 2'd0,
        REG_FRAME_HEIGHT = 2'd1,
        REG_COS_ANGLE    = 2'd2,
        REG_SIN_ANGLE    = 2'd3
    } reg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_SUM,
        ST_SHIFT,
        ST_ADDR,
        ST_READ
    } state_t;

    typedef struct packed {
        logic              action;
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  col;
        logic [CHAN_W-1:0] in_red;
        logic [CHAN_W-1:0] in_green;
        logic [CHAN_W-1:0] in_blue;
    } in_req_t;

    typedef struct packed {
        logic [CHAN_W-1:0] out_red;
        logic [CHAN_W-1:0] out_green;
        logic [CHAN_W-1:0] out_blue;
        logic              outside;
    } out_req_t;

    // Stage enables from the controller to the rotation datapath.
    typedef struct packed {
        logic load_en;
        logic mul_en;
        logic sum_en;
        logic shift_en;
        logic addr_en;
    } rot_ctrl_t;

endpackage

// File: rtl/crpf_frame_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crpf_frame_mem: frame store
// Single write port and single read port with registered read data.
// ----------------------------------------------------------------------------
module crpf_frame_mem #(
    parameter int ADDR_W = 19
) (
    input  logic                      clk,
    input  logic                      wr_en,
    input  logic [ADDR_W-1:0]         wr_addr,
    input  logic [crpf_pkg::PIX_W-1:0] wr_data,
    input  logic                      rd_en,
    input  logic [ADDR_W-1:0]         rd_addr,
    output logic [crpf_pkg::PIX_W-1:0] rd_data
);

    localparam int DEPTH = 1 << ADDR_W;

    logic [crpf_pkg::PIX_W-1:0] mem [0:DEPTH-1];
    logic [crpf_pkg::PIX_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read data holds until the next read, so a stalled result keeps it.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/crpf_rotate.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crpf_rotate: inverse rotation datapath
// Maps an output pixel to its source pixel about the frame center.
// ----------------------------------------------------------------------------
module crpf_rotate #(
    parameter int MAX_WIDTH      = crpf_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT     = crpf_pkg::DEF_MAX_HEIGHT,
    parameter int TRIG_FRAC_BITS = crpf_pkg::DEF_TRIG_FRAC_BITS,
    parameter int RA_W           = $clog2(MAX_HEIGHT),
    parameter int CA_W           = $clog2(MAX_WIDTH)
) (
    input  logic                          clk,
    input  crpf_pkg::rot_ctrl_t           ctrl,
    input  logic [crpf_pkg::ROW_W-1:0]    row,
    input  logic [crpf_pkg::COL_W-1:0]    col,
    input  logic [crpf_pkg::FW_W-1:0]     frame_width,
    input  logic [crpf_pkg::FH_W-1:0]     frame_height,
    input  logic signed [crpf_pkg::TRIG_W-1:0] cos_angle,
    input  logic signed [crpf_pkg::TRIG_W-1:0] sin_angle,
    output logic [RA_W+CA_W-1:0]          src_addr,
    output logic                          src_outside
);

    localparam int DIFF_W = crpf_pkg::DIFF_W;
    localparam int PROD_W = crpf_pkg::PROD_W;
    localparam int SUM_W  = crpf_pkg::SUM_W;
    localparam int FW_W   = crpf_pkg::FW_W;
    localparam int FH_W   = crpf_pkg::FH_W;
    localparam logic signed [SUM_W-1:0] ROUND_BIAS = SUM_W'((1 << TRIG_FRAC_BITS) - 1);

    logic [FW_W-1:0] w_eff;
    logic [FH_W-1:0] h_eff;

    logic [FW_W-1:0]            w_reg;
    logic [FH_W-1:0]            h_reg;
    logic [FW_W-2:0]            wc_reg;
    logic [FH_W-2:0]            hc_reg;
    logic signed [DIFF_W-1:0]   dr_reg, dr_next;
    logic signed [DIFF_W-1:0]   dc_reg, dc_next;

    logic signed [PROD_W-1:0]   dr_ext, dc_ext, cos_ext, sin_ext;
    logic signed [PROD_W-1:0]   p_rc_reg, p_ds_reg, p_dc_reg, p_rs_reg;

    logic signed [SUM_W-1:0]    s_r_reg, s_c_reg;
    logic signed [SUM_W-1:0]    b_r, b_c;
    logic signed [SUM_W-1:0]    q_r_reg, q_c_reg;

    logic signed [SUM_W-1:0]    sr, sc, h_ext, w_ext;
    logic                       src_in_frame;
    logic                       outside_reg;

    // Frame size registers above the store size saturate to the store size.
    always_comb
    begin
        w_eff   = (32'(frame_width) > MAX_WIDTH) ? FW_W'(MAX_WIDTH) : frame_width;
        h_eff   = (32'(frame_height) > MAX_HEIGHT) ? FH_W'(MAX_HEIGHT) : frame_height;
        dr_next = $signed({3'b000, row}) - $signed({3'b000, h_eff[FH_W-1:1]});
        dc_next = $signed({2'b00, col}) - $signed({2'b00, w_eff[FW_W-1:1]});
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load_en)
        begin
            w_reg  <= w_eff;
            h_reg  <= h_eff;
            wc_reg <= w_eff[FW_W-1:1];
            hc_reg <= h_eff[FH_W-1:1];
            dr_reg <= dr_next;
            dc_reg <= dc_next;
        end
    end

    assign dr_ext  = PROD_W'(dr_reg);
    assign dc_ext  = PROD_W'(dc_reg);
    assign cos_ext = PROD_W'(cos_angle);
    assign sin_ext = PROD_W'(sin_angle);

    always_ff @(posedge clk)
    begin
        if (ctrl.mul_en)
        begin
            p_rc_reg <= dr_ext * cos_ext;
            p_ds_reg <= dc_ext * sin_ext;
            p_dc_reg <= dc_ext * cos_ext;
            p_rs_reg <= dr_ext * sin_ext;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.sum_en)
        begin
            s_r_reg <= SUM_W'(p_rc_reg) + SUM_W'(p_ds_reg);
            s_c_reg <= SUM_W'(p_dc_reg) - SUM_W'(p_rs_reg);
        end
    end

    // Truncation toward zero: negative sums are biased up before the shift.
    assign b_r = s_r_reg + (s_r_reg[SUM_W-1] ? ROUND_BIAS : '0);
    assign b_c = s_c_reg + (s_c_reg[SUM_W-1] ? ROUND_BIAS : '0);

    always_ff @(posedge clk)
    begin
        if (ctrl.shift_en)
        begin
            q_r_reg <= b_r >>> TRIG_FRAC_BITS;
            q_c_reg <= b_c >>> TRIG_FRAC_BITS;
        end
    end

    always_comb
    begin
        sr     = q_r_reg + SUM_W'($signed({1'b0, hc_reg}));
        sc     = q_c_reg + SUM_W'($signed({1'b0, wc_reg}));
        h_ext  = SUM_W'($signed({1'b0, h_reg}));
        w_ext  = SUM_W'($signed({1'b0, w_reg}));
        src_in_frame = !sr[SUM_W-1] && (sr < h_ext) && !sc[SUM_W-1] && (sc < w_ext);
    end

    assign src_addr    = {sr[RA_W-1:0], sc[CA_W-1:0]};

    always_ff @(posedge clk)
    begin
        if (ctrl.addr_en)
        begin
            outside_reg <= !src_in_frame;
        end
    end

    assign src_outside = outside_reg;

`ifndef SYNTHESIS
    // A source inside the active frame is registered as not outside.
    property p_addr_in_frame;
        @(posedge clk) ctrl.addr_en && src_in_frame |=> !outside_reg;
    endproperty
    a_addr_in_frame: assert property (p_addr_in_frame)
        else $error("source in frame not flagged as such");

    property p_row_in_store;
        @(posedge clk) ctrl.addr_en && src_in_frame
            |-> 32'(src_addr[RA_W+CA_W-1:CA_W]) < MAX_HEIGHT;
    endproperty
    a_row_in_store: assert property (p_row_in_store)
        else $error("source row beyond frame store");

    property p_col_in_store;
        @(posedge clk) ctrl.addr_en && src_in_frame |-> 32'(src_addr[CA_W-1:0]) < MAX_WIDTH;
    endproperty
    a_col_in_store: assert property (p_col_in_store)
        else $error("source column beyond frame store");
`endif

endmodule

// File: rtl/center_rotation_pixel_fetch_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// center_rotation_pixel_fetch_unit: nearest-neighbor rotation about center
// Holds one RGB frame and returns rotated pixels on request.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (in_valid, in_ready, in_data) carries two kinds of
// request. A store request writes one pixel into the frame store at the
// edge it is accepted and gives no result; stores are taken one per cycle
// while no fetch is in progress. A fetch request names an output pixel;
// the block maps it back through the inverse rotation and returns the source
// pixel on the output channel (out_valid, out_ready, out_data), or black
// with the outside flag set when the source lies outside the active frame.
// A fetch walks a five-step sequence: center offsets, four products, two
// sums, truncating shift, then bounds check and frame store read. The block
// is ready again in the same cycle that the result becomes valid. The
// sequencer takes no request, store or fetch, until a fetch has left its
// read step, so no new request is taken while a fetch is in progress.
// The result sits in an output register; the sequence may run to the read
// step while a result waits, and stalls there only when the receiver holds
// off. The configuration registers come out of reset with a 640 x 480 frame
// and a zero angle; the frame store itself is not cleared.
// ----------------------------------------------------------------------------
module center_rotation_pixel_fetch_unit #(
    parameter int MAX_WIDTH      = crpf_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT     = crpf_pkg::DEF_MAX_HEIGHT,
    parameter int TRIG_FRAC_BITS = crpf_pkg::DEF_TRIG_FRAC_BITS
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  crpf_pkg::in_req_t               in_data,
    output logic                            out_valid,
    input  logic                            out_ready,
    output crpf_pkg::out_req_t              out_data,
    input  logic                            cfg_wen,
    input  logic [crpf_pkg::REG_IDX_W-1:0]  cfg_index,
    input  logic [crpf_pkg::CFG_W-1:0]      cfg_data
);

    // Rows and columns of the store are addressed by concatenation, so the
    // column field is rounded up to a power of two.
    localparam int RA_W   = $clog2(MAX_HEIGHT);
    localparam int CA_W   = $clog2(MAX_WIDTH);
    localparam int ADDR_W = RA_W + CA_W;

    // Config registers, unchecked: software must write them only while idle.
    logic [crpf_pkg::FW_W-1:0]          frame_width_reg;
    logic [crpf_pkg::FH_W-1:0]          frame_height_reg;
    logic signed [crpf_pkg::TRIG_W-1:0] cos_angle_reg;
    logic signed [crpf_pkg::TRIG_W-1:0] sin_angle_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= crpf_pkg::RST_FRAME_WIDTH;
            frame_height_reg <= crpf_pkg::RST_FRAME_HEIGHT;
            cos_angle_reg    <= crpf_pkg::RST_COS_ANGLE;
            sin_angle_reg    <= crpf_pkg::RST_SIN_ANGLE;
        end
        else if (cfg_wen)
        begin
            case (crpf_pkg::reg_idx_t'(cfg_index))
                crpf_pkg::REG_FRAME_WIDTH:  frame_width_reg  <= cfg_data[crpf_pkg::FW_W-1:0];
                crpf_pkg::REG_FRAME_HEIGHT: frame_height_reg <= cfg_data[crpf_pkg::FH_W-1:0];
                crpf_pkg::REG_COS_ANGLE:    cos_angle_reg    <= cfg_data;
                crpf_pkg::REG_SIN_ANGLE:    sin_angle_reg    <= cfg_data;
                default:                    frame_width_reg  <= frame_width_reg;
            endcase
        end
    end

    // Sequencer state and output register.
    crpf_pkg::state_t    state_reg, state_next;
    crpf_pkg::rot_ctrl_t ctrl;
    logic                out_valid_reg, out_valid_next;
    crpf_pkg::out_req_t  out_data_reg, out_data_next;
    logic                in_accept;
    logic                load_out;
    logic                store_en;

    logic [ADDR_W-1:0]          src_addr;
    logic                       src_outside;
    logic [crpf_pkg::PIX_W-1:0] rd_data;

    assign in_accept = in_valid && in_ready;

    // A store is dropped when its position lies beyond the frame store.
    assign store_en = in_accept && (in_data.action == crpf_pkg::ACT_STORE)
                      && (32'(in_data.row) < MAX_HEIGHT)
                      && (32'(in_data.col) < MAX_WIDTH);

    always_comb
    begin
        state_next     = state_reg;
        in_ready       = 1'b0;
        load_out       = 1'b0;
        ctrl           = '0;
        case (state_reg)
            crpf_pkg::ST_IDLE:
            begin
                in_ready     = 1'b1;
                ctrl.load_en = in_valid && (in_data.action == crpf_pkg::ACT_FETCH);
                if (ctrl.load_en)
                begin
                    state_next = crpf_pkg::ST_MUL;
                end
            end
            crpf_pkg::ST_MUL:
            begin
                ctrl.mul_en = 1'b1;
                state_next  = crpf_pkg::ST_SUM;
            end
            crpf_pkg::ST_SUM:
            begin
                ctrl.sum_en = 1'b1;
                state_next  = crpf_pkg::ST_SHIFT;
            end
            crpf_pkg::ST_SHIFT:
            begin
                ctrl.shift_en = 1'b1;
                state_next    = crpf_pkg::ST_ADDR;
            end
            crpf_pkg::ST_ADDR:
            begin
                // The frame store read is issued here; data arrives next cycle.
                ctrl.addr_en = 1'b1;
                state_next   = crpf_pkg::ST_READ;
            end
            crpf_pkg::ST_READ:
            begin
                // Wait here while the previous result is still held off.
                load_out = !out_valid_reg || out_ready;
                if (load_out)
                begin
                    state_next = crpf_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = crpf_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && !out_ready;
        out_data_next  = out_data_reg;
        if (load_out)
        begin
            out_valid_next         = 1'b1;
            out_data_next.outside  = src_outside;
            if (src_outside)
            begin
                out_data_next.out_red   = '0;
                out_data_next.out_green = '0;
                out_data_next.out_blue  = '0;
            end
            else
            begin
                out_data_next.out_red   = rd_data[23:16];
                out_data_next.out_green = rd_data[15:8];
                out_data_next.out_blue  = rd_data[7:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= crpf_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    crpf_rotate #(
        .MAX_WIDTH      (MAX_WIDTH),
        .MAX_HEIGHT     (MAX_HEIGHT),
        .TRIG_FRAC_BITS (TRIG_FRAC_BITS),
        .RA_W           (RA_W),
        .CA_W           (CA_W)
    ) u_rotate (
        .clk          (clk),
        .ctrl         (ctrl),
        .row          (in_data.row),
        .col          (in_data.col),
        .frame_width  (frame_width_reg),
        .frame_height (frame_height_reg),
        .cos_angle    (cos_angle_reg),
        .sin_angle    (sin_angle_reg),
        .src_addr     (src_addr),
        .src_outside  (src_outside)
    );

    crpf_frame_mem #(
        .ADDR_W (ADDR_W)
    ) u_frame_mem (
        .clk     (clk),
        .wr_en   (store_en),
        .wr_addr ({RA_W'(in_data.row), CA_W'(in_data.col)}),
        .wr_data ({in_data.in_red, in_data.in_green, in_data.in_blue}),
        .rd_en   (ctrl.addr_en),
        .rd_addr (src_addr),
        .rd_data (rd_data)
    );

`ifndef SYNTHESIS
    // An accepted fetch walks the whole sequence without skipping a step.
    property p_fetch_sequence;
        @(posedge clk) disable iff (!rst_n)
        in_accept && (in_data.action == crpf_pkg::ACT_FETCH)
            |=> (state_reg == crpf_pkg::ST_MUL) ##1 (state_reg == crpf_pkg::ST_SUM)
                ##1 (state_reg == crpf_pkg::ST_SHIFT) ##1 (state_reg == crpf_pkg::ST_ADDR)
                ##1 (state_reg == crpf_pkg::ST_READ);
    endproperty
    a_fetch_sequence: assert property (p_fetch_sequence)
        else $error("fetch sequence broken");

    // A held result is never overwritten by the waiting fetch.
    property p_read_waits;
        @(posedge clk) disable iff (!rst_n)
        (state_reg == crpf_pkg::ST_READ) && out_valid && !out_ready
            |=> (state_reg == crpf_pkg::ST_READ) && out_valid;
    endproperty
    a_read_waits: assert property (p_read_waits)
        else $error("result overwritten while stalled");

    // An outside result carries black.
    property p_outside_black;
        @(posedge clk) disable iff (!rst_n)
        out_valid && out_data.outside
            |-> (out_data.out_red == '0) && (out_data.out_green == '0)
                && (out_data.out_blue == '0);
    endproperty
    a_outside_black: assert property (p_outside_black)
        else $error("outside result is not black");

    // No store lands while a fetch is in the sequence.
    property p_no_store_busy;
        @(posedge clk) disable iff (!rst_n)
        store_en |-> (state_reg == crpf_pkg::ST_IDLE);
    endproperty
    a_no_store_busy: assert property (p_no_store_busy)
        else $error("store during fetch sequence");
`endif

endmodule

// File: bench/tb_center_rotation_pixel_fetch_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_center_rotation_pixel_fetch_unit: self-checking bench for the rotator
// Stores pixels into the frame store, then fetches rotated pixels under a
// range of frame sizes and angles. Every fetch result is checked field by
// field against a listed pixel or a bench model of inverse rotation and store.
// ----------------------------------------------------------------------------
module tb_center_rotation_pixel_fetch_unit;

    import crpf_pkg::*;

    localparam int     MAX_W           = DEF_MAX_WIDTH;
    localparam int     MAX_H           = DEF_MAX_HEIGHT;
    localparam longint TRIG_SCALE      = longint'(1) << DEF_TRIG_FRAC_BITS;
    localparam real    TRIG_ONE        = real'(1 << DEF_TRIG_FRAC_BITS);
    localparam int     RANDOM_ITEMS    = 600;
    localparam int     HOLD_OFF_CYCLES = 200;
    // Settling time after the last owed pixel, longer than a fetch takes to answer.
    localparam int     QUIET_CYCLES    = 10;
    localparam int     TIMEOUT_NS      = 5_000_000;
    localparam int     MAX_PRINTED     = 30;

    // Common angles: 0, 90, 180, 270, 45 and -45 degrees.
    localparam int ANGLE_COS [6] = '{16384, 0, -16384, 0, 11585, 11585};
    localparam int ANGLE_SIN [6] = '{0, 16384, 0, -16384, 11585, -11585};

    localparam out_req_t PIX_OUTSIDE = '{8'h00, 8'h00, 8'h00, 1'b1};

    // The directed part is a list of steps. A register step is applied only
    // once the block has gone quiet. A known step carries its expected pixel;
    // a predicted step is checked against the bench model instead.
    typedef enum logic [1:0] {
        STEP_CONFIG,
        STEP_STORE,
        STEP_KNOWN,
        STEP_PREDICT
    } step_kind_t;

    typedef struct packed {
        step_kind_t       kind;
        reg_idx_t         reg_idx;
        logic [CFG_W-1:0] reg_value;
        in_req_t          req;
        out_req_t         want;
    } directed_step_t;

    localparam int NUM_STEPS = 33;

    localparam directed_step_t DIRECTED_STEPS [NUM_STEPS] = '{
        // Reset settings: 640 x 480 frame, zero angle, so a fetch reads
        // back the same position when it lies inside the frame.
        '{STEP_STORE, REG_FRAME_WIDTH, 16'h0000,
          '{ACT_STORE, 9'd0, 10'd0, 8'hFF, 8'h00, 8'h80}, '0},
        '{STEP_KNOWN, REG_FRAME_WIDTH, 16'h0000,
          '{ACT_FETCH, 9'd0, 10'd0, 8'h00, 8'h00, 8'h00}, '{8'hFF, 8'h00, 8'h80, 1'b0}},
        '{STEP_STORE, REG_FRAME_WIDTH, 16'h0000,
          '{ACT_STORE, 9'd479, 10'd639, 8'h00, 8'hFF, 8'h7F}, '0},
        '{STEP_KNOWN, REG_FRAME_WIDTH, 16'h0000,
          '{ACT_FETCH, 9'd479, 10'd639, 8'h00, 8'h00, 8'h00}, '{8'h00, 8'hFF, 8'h7F, 1'b0}},
        '{STEP_KNOWN, REG_FRAME_WIDTH, 16'h0000,
          '{ACT_FETCH, 9'd480, 10'd0, 8'h00, 8'h00, 8'h00}, PIX_OUTSIDE},
        '{STEP_KNOWN, REG_FRAME_WIDTH, 16'h0000,
          '{ACT_FETCH, 9'd0, 10'd640, 8'h00, 8'h00, 8'h00}, PIX_OUTSIDE},
        // A store outside the active frame still lands in the store.
        '{STEP_STORE, REG_FRAME_WIDTH, 16'h0000,
          '{ACT_STORE, 9'd511, 10'd1023, 8'hFF, 8'hFF, 8'hFF}, '0},
        '{STEP_KNOWN, REG_FRAME_WIDTH, 16'h0000,
          '{ACT_FETCH, 9'd511, 10'd1023, 8'h00, 8'h00, 8'h00}, PIX_OUTSIDE},
        '{STEP_STORE, REG_FRAME_WIDTH, 16'h0000,
          '{ACT_STORE, 9'd256, 10'd512, 8'h00, 8'h00, 8'h00}, '0},
        // Oversized frame registers clamp to the full 1024 x 512 store.
        '{STEP_CONFIG, REG_FRAME_WIDTH, 16'hFFFF, '0, '0},
        '{STEP_CONFIG, REG_FRAME_HEIGHT, 16'hFFFF, '0, '0},
        '{STEP_KNOWN, REG_FRAME_WIDTH, 16'h0000,
          '{ACT_FETCH, 9'd511, 10'd1023, 8'h00, 8'h00, 8'h00}, '{8'hFF, 8'hFF, 8'hFF, 1'b0}},
        '{STEP_KNOWN, REG_FRAME_WIDTH, 16'h0000,
          '{ACT_FETCH, 9'd256, 10'd512, 8'h00, 8'h00, 8'h00}, '{8'h00, 8'h00, 8'h00, 1'b0}},
        // A zero width puts every source outside.
        '{STEP_CONFIG, REG_FRAME_WIDTH, 16'h0000, '0, '0},
        '{STEP_KNOWN, REG_FRAME_WIDTH, 16'h0000,
          '{ACT_FETCH, 9'd0, 10'd0, 8'h00, 8'h00, 8'h00}, PIX_OUTSIDE},
        // Half turn about (256, 512): (1, 1) maps onto the far corner.
        '{STEP_CONFIG, REG_FRAME_WIDTH, 16'h0400, '0, '0},
        '{STEP_CONFIG, REG_COS_ANGLE, 16'hC000, '0, '0},
        '{STEP_KNOWN, REG_FRAME_WIDTH, 16'h0000,
          '{ACT_FETCH, 9'd1, 10'd1, 8'h00, 8'h00, 8'h00}, '{8'hFF, 8'hFF, 8'hFF, 1'b0}},
        '{STEP_KNOWN, REG_FRAME_WIDTH, 16'h0000,
          '{ACT_FETCH, 9'd0, 10'd0, 8'h00, 8'h00, 8'h00}, PIX_OUTSIDE},
        // Quarter turn.
        '{STEP_CONFIG, REG_COS_ANGLE, 16'h0000, '0, '0},
        '{STEP_CONFIG, REG_SIN_ANGLE, 16'h4000, '0, '0},
        '{STEP_PREDICT, REG_FRAME_WIDTH, 16'h0000,
          '{ACT_FETCH, 9'd100, 10'd300, 8'h00, 8'h00, 8'h00}, '0},
        '{STEP_PREDICT, REG_FRAME_WIDTH, 16'h0000,
          '{ACT_FETCH, 9'd511, 10'd0, 8'h00, 8'h00, 8'h00}, '0},
        // Register extremes beyond unit length.
        '{STEP_CONFIG, REG_COS_ANGLE, 16'h7FFF, '0, '0},
        '{STEP_CONFIG, REG_SIN_ANGLE, 16'h8000, '0, '0},
        '{STEP_PREDICT, REG_FRAME_WIDTH, 16'h0000,
          '{ACT_FETCH, 9'd0, 10'd1023, 8'h00, 8'h00, 8'h00}, '0},
        '{STEP_PREDICT, REG_FRAME_WIDTH, 16'h0000,
          '{ACT_FETCH, 9'd300, 10'd5, 8'h00, 8'h00, 8'h00}, '0},
        // Tiny odd frame at -45 degrees: negative sums truncate toward zero.
        '{STEP_CONFIG, REG_FRAME_WIDTH, 16'h0007, '0, '0},
        '{STEP_CONFIG, REG_FRAME_HEIGHT, 16'h0005, '0, '0},
        '{STEP_CONFIG, REG_COS_ANGLE, 16'h2D41, '0, '0},
        '{STEP_CONFIG, REG_SIN_ANGLE, 16'hD2BF, '0, '0},
        '{STEP_PREDICT, REG_FRAME_WIDTH, 16'h0000,
          '{ACT_FETCH, 9'd0, 10'd0, 8'h00, 8'h00, 8'h00}, '0},
        '{STEP_PREDICT, REG_FRAME_WIDTH, 16'h0000,
          '{ACT_FETCH, 9'd4, 10'd6, 8'h00, 8'h00, 8'h00}, '0}
    };

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b1;
    logic                 in_valid  = 1'b0;
    logic                 in_ready;
    in_req_t              in_data   = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    out_req_t             out_data;
    logic                 cfg_wen   = 1'b0;
    logic [REG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data  = '0;

    // Bench copy of the configuration, tracked through every write.
    logic [FW_W-1:0]          cur_width  = RST_FRAME_WIDTH;
    logic [FH_W-1:0]          cur_height = RST_FRAME_HEIGHT;
    logic signed [TRIG_W-1:0] cur_cos    = RST_COS_ANGLE;
    logic signed [TRIG_W-1:0] cur_sin    = RST_SIN_ANGLE;

    // Bench copy of every pixel written so far, keyed by row * MAX_W + col.
    // Entries that are absent were never written and are never fetched.
    logic [PIX_W-1:0] frame_copy [int];

    // Pixels still owed by the block, oldest first.
    out_req_t pending_pixels [$];

    bit sender_steady   = 1'b0;
    bit receiver_steady = 1'b0;
    bit hold_off_armed  = 1'b0;

    int items_sent    = 0;
    int stores_sent   = 0;
    int fetches_sent  = 0;
    int results_seen  = 0;
    int outside_seen  = 0;
    int config_writes = 0;
    int hold_offs     = 0;
    int mismatches    = 0;

    out_req_t want_px;

    center_rotation_pixel_fetch_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Idle lengths: mostly none or short, now and then a long one.
    function automatic int idle_cycles();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        if (roll < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Frame extent for a random phase. Small frames are frequent so that fetches
    // often land inside; the full store, oversized values and zero also come.
    function automatic logic [CFG_W-1:0] pick_extent(input int limit, input int field_w);
        int roll;
        int v;
        roll = $urandom_range(0, 19);
        if (roll == 0)
            v = 0;
        else if (roll < 8)
            v = $urandom_range(1, 8);
        else if (roll < 11)
            v = limit;
        else if (roll < 13)
            v = $urandom_range(limit + 1, (1 << field_w) - 1);
        else
            v = $urandom_range(1, limit);
        return CFG_W'(v);
    endfunction

    function automatic in_req_t make_request(input logic act, input int r, input int c);
        in_req_t req;
        req.action   = act;
        req.row      = ROW_W'(r);
        req.col      = COL_W'(c);
        req.in_red   = CHAN_W'($urandom);
        req.in_green = CHAN_W'($urandom);
        req.in_blue  = CHAN_W'($urandom);
        return req;
    endfunction

    // Inverse rotation about the integer frame center. Returns the store key
    // of the source pixel, or -1 when the source falls outside the frame.
    // SystemVerilog division of signed values truncates toward zero.
    function automatic int source_index(input logic [ROW_W-1:0] r, input logic [COL_W-1:0] c);
        longint w;
        longint h;
        longint dr;
        longint dc;
        longint sr;
        longint sc;
        w = longint'(cur_width);
        h = longint'(cur_height);
        if (w > MAX_W)
            w = MAX_W;
        if (h > MAX_H)
            h = MAX_H;
        dr = longint'(r) - h / 2;
        dc = longint'(c) - w / 2;
        sr = (dr * longint'(cur_cos) + dc * longint'(cur_sin)) / TRIG_SCALE + h / 2;
        sc = (dc * longint'(cur_cos) - dr * longint'(cur_sin)) / TRIG_SCALE + w / 2;
        if (sr < 0 || sr >= h || sc < 0 || sc >= w)
            return -1;
        return int'(sr * MAX_W + sc);
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (mismatches < MAX_PRINTED)
            $display("[%0t] mismatch: %s: got %0h, expected %0h", $time, what, got, want);
        mismatches++;
    endtask

    // Offers one request and waits for its handshake. Valid stays high from
    // one request to the next unless a gap is drawn. The expected pixel of a
    // fetch is taken at acceptance, with the store and settings of that edge.
    task automatic send_request(input in_req_t req, input bit known, input out_req_t known_px);
        int gap;
        int src;
        out_req_t px;
        gap = sender_steady ? 0 : idle_cycles();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= req;
        do @(posedge clk); while (!in_ready);
        items_sent++;
        if (req.action == ACT_STORE)
        begin
            frame_copy[int'(req.row) * MAX_W + int'(req.col)] =
                {req.in_red, req.in_green, req.in_blue};
            stores_sent++;
        end
        else
        begin
            src = source_index(req.row, req.col);
            if (known)
                px = known_px;
            else if (src < 0)
                px = PIX_OUTSIDE;
            else
                px = {frame_copy[src], 1'b0};
            pending_pixels = {pending_pixels, px};
            fetches_sent++;
        end
    endtask

    // A fetch whose source lies inside the frame but on a pixel never
    // written is preceded by a store to that pixel, so the block never reads
    // an undefined entry.
    task automatic fetch_pixel(input int r, input int c);
        int src;
        src = source_index(ROW_W'(r), COL_W'(c));
        if (src >= 0 && !frame_copy.exists(src))
            send_request(make_request(ACT_STORE, src / MAX_W, src % MAX_W), 1'b0, '0);
        send_request(make_request(ACT_FETCH, r, c), 1'b0, '0);
    endtask

    // Holds the sender off until every owed pixel has arrived, then lets the
    // block settle, since a store gives no result to wait for.
    task automatic quiesce();
        in_valid <= 1'b0;
        while (pending_pixels.size() != 0)
            @(posedge clk);
        repeat (QUIET_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input reg_idx_t idx, input logic [CFG_W-1:0] value);
        cfg_wen   <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_wen <= 1'b0;
        case (idx)
            REG_FRAME_WIDTH:  cur_width  = value[FW_W-1:0];
            REG_FRAME_HEIGHT: cur_height = value[FH_W-1:0];
            REG_COS_ANGLE:    cur_cos    = value;
            REG_SIN_ANGLE:    cur_sin    = value;
            default:          ;
        endcase
        config_writes++;
        @(posedge clk);
    endtask

    // Result side: every accepted pixel is compared with the oldest one owed.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            results_seen++;
            if (out_data.outside === 1'b1)
                outside_seen++;
            if (pending_pixels.size() == 0)
                report_mismatch("result with no fetch pending", 32'(out_data), 32'd0);
            else
            begin
                want_px = pending_pixels.pop_front();
                if (out_data.out_red !== want_px.out_red)
                    report_mismatch("out_red", 32'(out_data.out_red), 32'(want_px.out_red));
                if (out_data.out_green !== want_px.out_green)
                    report_mismatch("out_green", 32'(out_data.out_green),
                                    32'(want_px.out_green));
                if (out_data.out_blue !== want_px.out_blue)
                    report_mismatch("out_blue", 32'(out_data.out_blue), 32'(want_px.out_blue));
                if (out_data.outside !== want_px.outside)
                    report_mismatch("outside", 32'(out_data.outside), 32'(want_px.outside));
            end
        end
    end

    // Receiver: random stalls in most phases, none in steady phases, and on
    // request one long hold-off counted here, long enough that the block
    // backs up and stops taking requests.
    initial
    begin : receiver
        int stall;
        @(posedge clk);
        forever
        begin
            if (hold_off_armed)
            begin
                hold_off_armed = 1'b0;
                hold_offs++;
                out_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
            end
            else if (!receiver_steady && $urandom_range(0, 3) == 0)
            begin
                stall = 1 + idle_cycles();
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            else
            begin
                out_ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    initial
    begin : stimulus
        int i;
        int r;
        int c;
        int k;
        int roll;
        int phase_no;
        int phase_items;
        int first_item;
        int directed_items;
        int eff_w;
        int eff_h;
        int cos_v;
        int sin_v;
        bit drained;
        real angle_rad;

        rst_n <= 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed steps.
        for (i = 0; i < NUM_STEPS; i++)
        begin
            case (DIRECTED_STEPS[i].kind)
                STEP_CONFIG:
                begin
                    quiesce();
                    write_register(DIRECTED_STEPS[i].reg_idx, DIRECTED_STEPS[i].reg_value);
                end
                STEP_STORE:
                    send_request(DIRECTED_STEPS[i].req, 1'b0, '0);
                STEP_KNOWN:
                    send_request(DIRECTED_STEPS[i].req, 1'b1, DIRECTED_STEPS[i].want);
                default:
                    fetch_pixel(int'(DIRECTED_STEPS[i].req.row),
                                int'(DIRECTED_STEPS[i].req.col));
            endcase
        end
        directed_items = items_sent;

        // Random phases: new settings for all four registers, then stores and
        // fetches mostly aimed at and around the active frame.
        phase_no = 0;
        while (items_sent - directed_items < RANDOM_ITEMS)
        begin
            quiesce();
            write_register(REG_FRAME_WIDTH, pick_extent(MAX_W, FW_W));
            write_register(REG_FRAME_HEIGHT, pick_extent(MAX_H, FH_W));
            roll = $urandom_range(0, 9);
            if (roll < 4)
            begin
                k = $urandom_range(0, 5);
                cos_v = ANGLE_COS[k];
                sin_v = ANGLE_SIN[k];
            end
            else if (roll < 8)
            begin
                angle_rad = $urandom_range(0, 3599) * 3.14159265 / 1800.0;
                cos_v = $rtoi($cos(angle_rad) * TRIG_ONE);
                sin_v = $rtoi($sin(angle_rad) * TRIG_ONE);
            end
            else
            begin
                cos_v = $urandom_range(0, 65535);
                sin_v = $urandom_range(0, 65535);
            end
            write_register(REG_COS_ANGLE, CFG_W'(cos_v));
            write_register(REG_SIN_ANGLE, CFG_W'(sin_v));

            sender_steady   = ($urandom_range(0, 3) == 0);
            receiver_steady = ($urandom_range(0, 3) == 0);
            eff_w = (int'(cur_width) > MAX_W) ? MAX_W : int'(cur_width);
            eff_h = (int'(cur_height) > MAX_H) ? MAX_H : int'(cur_height);

            // A small frame is filled completely first, as a video source
            // would, so that the fetches after it read a whole image.
            if (eff_w * eff_h > 0 && eff_w * eff_h <= 48)
                for (r = 0; r < eff_h; r++)
                    for (c = 0; c < eff_w; c++)
                        send_request(make_request(ACT_STORE, r, c), 1'b0, '0);

            if (phase_no == 1 || phase_no == 4)
                hold_off_armed = 1'b1;

            phase_items = $urandom_range(40, 90);
            first_item  = items_sent;
            drained     = 1'b0;
            while (items_sent - first_item < phase_items)
            begin
                if (!drained && items_sent - first_item >= phase_items / 2)
                begin
                    drained = 1'b1;
                    if (phase_no == 0 || $urandom_range(0, 1) == 0)
                        quiesce();
                end
                r = $urandom_range(0, (eff_h + 3 > MAX_H - 1) ? MAX_H - 1 : eff_h + 3);
                c = $urandom_range(0, (eff_w + 3 > MAX_W - 1) ? MAX_W - 1 : eff_w + 3);
                roll = $urandom_range(0, 99);
                if (roll < 30)
                    send_request(make_request(ACT_STORE, r, c), 1'b0, '0);
                else if (roll < 85)
                    fetch_pixel(r, c);
                else if (roll < 93)
                    send_request(make_request(ACT_STORE, $urandom_range(0, MAX_H - 1),
                                              $urandom_range(0, MAX_W - 1)), 1'b0, '0);
                else
                    fetch_pixel($urandom_range(0, MAX_H - 1), $urandom_range(0, MAX_W - 1));
            end
            phase_no++;
        end

        sender_steady   = 1'b0;
        receiver_steady = 1'b0;
        quiesce();

        $display("Covered %0d requests (%0d stores, %0d fetches) over %0d register writes.",
                 items_sent, stores_sent, fetches_sent, config_writes);
        $display("Checked %0d pixels, %0d of them outside; %0d long hold-offs; %0d mismatches.",
                 results_seen, outside_seen, hold_offs, mismatches);
        if (mismatches == 0)
            $display("** center_rotation_pixel_fetch_unit: PASSED **");
        else
            $display("** center_rotation_pixel_fetch_unit: FAILED **");
        $finish;
    end

    // Watchdog: a hung handshake ends the run here.
    initial
    begin
        #(TIMEOUT_NS);
        $display("Timeout with %0d pixels still owed.", pending_pixels.size());
        $display("** center_rotation_pixel_fetch_unit: FAILED **");
        $finish;
    end

endmodule

// File: files.f
rtl/crpf_pkg.sv
rtl/crpf_frame_mem.sv
rtl/crpf_rotate.sv
rtl/center_rotation_pixel_fetch_unit.sv
bench/tb_center_rotation_pixel_fetch_unit.sv
